FILE: src/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg
// shared types and constants for the midpoint line rasterizer
// ----------------------------------------------------------------------------
package mlr_pkg;

    localparam int COORD_BITS = 6;
    localparam int DEC_BITS   = COORD_BITS + 4;
    localparam int INC_BITS   = COORD_BITS + 3;

    typedef enum logic [1:0] {
        OCT_SHALLOW_POS = 2'd0,
        OCT_SHALLOW_NEG = 2'd1,
        OCT_STEEP_POS   = 2'd2,
        OCT_STEEP_NEG   = 2'd3
    } octant_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;
    } dp_status_t;

endpackage

FILE: src/mlr_datapath.sv
// ----------------------------------------------------------------------------
// mlr_datapath
// line setup, walk coordinates and midpoint decision stepping
// ----------------------------------------------------------------------------
module mlr_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  mlr_pkg::dp_cmd_t                  cmd,
    output mlr_pkg::dp_status_t               status,
    input  logic [mlr_pkg::COORD_BITS-1:0]    start_x,
    input  logic [mlr_pkg::COORD_BITS-1:0]    start_y,
    input  logic [mlr_pkg::COORD_BITS-1:0]    end_x,
    input  logic [mlr_pkg::COORD_BITS-1:0]    end_y,
    output logic [mlr_pkg::COORD_BITS-1:0]    pixel_x,
    output logic [mlr_pkg::COORD_BITS-1:0]    pixel_y,
    output logic                              last_pixel
);

    localparam int CB = mlr_pkg::COORD_BITS;
    localparam int DB = mlr_pkg::DEC_BITS;
    localparam int IB = mlr_pkg::INC_BITS;

    logic [CB-1:0]        walk_x_reg, walk_x_next;
    logic [CB-1:0]        walk_y_reg, walk_y_next;
    logic signed [DB-1:0] decision_reg, decision_next;
    logic signed [IB-1:0] straight_inc_reg, straight_inc_next;
    logic signed [IB-1:0] diagonal_inc_reg, diagonal_inc_next;
    logic [CB-1:0]        stop_coord_reg, stop_coord_next;
    mlr_pkg::octant_t     octant_reg, octant_next;
    logic [CB-1:0]        count_reg, count_next;

    logic [CB-1:0]        ax, ay, bx, by;
    logic signed [DB-1:0] dx, dy, neg_dy;
    logic signed [DB-1:0] init_dec;
    logic signed [DB-1:0] init_straight, init_diagonal;
    mlr_pkg::octant_t     init_octant;
    logic [CB-1:0]        init_stop;

    logic                 diag;
    logic signed [IB-1:0] inc_sel;
    logic                 at_stop;

    // setup: order endpoints by x, classify slope
    always_comb
    begin
        if (end_x < start_x)
        begin
            ax = end_x;
            ay = end_y;
            bx = start_x;
            by = start_y;
        end
        else
        begin
            ax = start_x;
            ay = start_y;
            bx = end_x;
            by = end_y;
        end
        dx     = $signed(DB'(bx)) - $signed(DB'(ax));
        dy     = $signed(DB'(by)) - $signed(DB'(ay));
        neg_dy = -dy;

        if (!dy[DB-1] && (dy <= dx))
        begin
            init_octant   = mlr_pkg::OCT_SHALLOW_POS;
            init_dec      = (dy <<< 1) - dx;
            init_straight = dy <<< 1;
            init_diagonal = (dy - dx) <<< 1;
            init_stop     = bx;
        end
        else if (dy[DB-1] && (neg_dy <= dx))
        begin
            init_octant   = mlr_pkg::OCT_SHALLOW_NEG;
            init_dec      = (dy <<< 1) + dx;
            init_straight = dy <<< 1;
            init_diagonal = (dy + dx) <<< 1;
            init_stop     = bx;
        end
        else if (dy > dx)
        begin
            init_octant   = mlr_pkg::OCT_STEEP_POS;
            init_dec      = (dx <<< 1) - dy;
            init_straight = dx <<< 1;
            init_diagonal = (dx - dy) <<< 1;
            init_stop     = by;
        end
        else
        begin
            init_octant   = mlr_pkg::OCT_STEEP_NEG;
            init_dec      = dy + (dx <<< 1);
            init_straight = dx <<< 1;
            init_diagonal = (dy + dx) <<< 1;
            init_stop     = by;
        end
    end

    // walk step
    always_comb
    begin
        if (octant_reg == mlr_pkg::OCT_SHALLOW_NEG)
            diag = (decision_reg <= 0);
        else
            diag = (decision_reg > 0);

        inc_sel = diag ? diagonal_inc_reg : straight_inc_reg;

        if ((octant_reg == mlr_pkg::OCT_SHALLOW_POS) || (octant_reg == mlr_pkg::OCT_SHALLOW_NEG))
            at_stop = (walk_x_reg == stop_coord_reg);
        else
            at_stop = (walk_y_reg == stop_coord_reg);

        walk_x_next       = walk_x_reg;
        walk_y_next       = walk_y_reg;
        decision_next     = decision_reg;
        straight_inc_next = straight_inc_reg;
        diagonal_inc_next = diagonal_inc_reg;
        stop_coord_next   = stop_coord_reg;
        octant_next       = octant_reg;
        count_next        = count_reg;

        if (cmd.load)
        begin
            walk_x_next       = ax;
            walk_y_next       = ay;
            decision_next     = init_dec;
            straight_inc_next = init_straight[IB-1:0];
            diagonal_inc_next = init_diagonal[IB-1:0];
            stop_coord_next   = init_stop;
            octant_next       = init_octant;
            count_next        = '0;
        end
        else if (cmd.step)
        begin
            decision_next = decision_reg + {{(DB-IB){inc_sel[IB-1]}}, inc_sel};
            count_next    = count_reg + 1'b1;
            case (octant_reg)
                mlr_pkg::OCT_SHALLOW_POS:
                begin
                    walk_x_next = walk_x_reg + 1'b1;
                    if (diag)
                        walk_y_next = walk_y_reg + 1'b1;
                end
                mlr_pkg::OCT_SHALLOW_NEG:
                begin
                    walk_x_next = walk_x_reg + 1'b1;
                    if (diag)
                        walk_y_next = walk_y_reg - 1'b1;
                end
                mlr_pkg::OCT_STEEP_POS:
                begin
                    walk_y_next = walk_y_reg + 1'b1;
                    if (diag)
                        walk_x_next = walk_x_reg + 1'b1;
                end
                default:
                begin
                    walk_y_next = walk_y_reg - 1'b1;
                    if (diag)
                        walk_x_next = walk_x_reg + 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_x_reg       <= '0;
            walk_y_reg       <= '0;
            decision_reg     <= '0;
            straight_inc_reg <= '0;
            diagonal_inc_reg <= '0;
            stop_coord_reg   <= '0;
            octant_reg       <= mlr_pkg::OCT_SHALLOW_POS;
            count_reg        <= '0;
        end
        else
        begin
            walk_x_reg       <= walk_x_next;
            walk_y_reg       <= walk_y_next;
            decision_reg     <= decision_next;
            straight_inc_reg <= straight_inc_next;
            diagonal_inc_reg <= diagonal_inc_next;
            stop_coord_reg   <= stop_coord_next;
            octant_reg       <= octant_next;
            count_reg        <= count_next;
        end
    end

    // pixel count cap keeps the line at most one tile width long
    assign status.last = at_stop || (count_reg == {CB{1'b1}});
    assign pixel_x     = walk_x_reg;
    assign pixel_y     = walk_y_reg;
    assign last_pixel  = status.last;

endmodule

FILE: src/mlr_controller.sv
// ----------------------------------------------------------------------------
// mlr_controller
// sequences command load and per-pixel stepping
// ----------------------------------------------------------------------------
module mlr_controller
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    output logic                  pix_valid,
    input  logic                  pix_ready,
    output mlr_pkg::dp_cmd_t      cmd,
    input  mlr_pkg::dp_status_t   status
);

    mlr_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mlr_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_ready  = 1'b0;
        pix_valid  = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        case (state_reg)
            mlr_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = mlr_pkg::ST_WALK;
                end
            end
            mlr_pkg::ST_WALK:
            begin
                pix_valid = 1'b1;
                if (pix_ready)
                begin
                    if (status.last)
                        state_next = mlr_pkg::ST_IDLE;
                    else
                        cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = mlr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/midpoint_line_rasterizer.sv
// latency: first pixel is offered the cycle after a command item is accepted
// throughput: one pixel item per cycle while pix_ready is high; a line has 1 to 64
// pixels, and the controller passes through the idle state after each line to take
// the next command
// reset: rst_n asynchronous active low, returns to idle with cmd_ready high
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// walks an integer midpoint line between two endpoints, one pixel per item
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  logic [mlr_pkg::COORD_BITS-1:0]    start_x,
    input  logic [mlr_pkg::COORD_BITS-1:0]    start_y,
    input  logic [mlr_pkg::COORD_BITS-1:0]    end_x,
    input  logic [mlr_pkg::COORD_BITS-1:0]    end_y,
    output logic                              pix_valid,
    input  logic                              pix_ready,
    output logic [mlr_pkg::COORD_BITS-1:0]    pixel_x,
    output logic [mlr_pkg::COORD_BITS-1:0]    pixel_y,
    output logic                              last_pixel
);

    mlr_pkg::dp_cmd_t    dp_cmd;
    mlr_pkg::dp_status_t dp_status;

    mlr_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

    mlr_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .status     (dp_status),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// line commands go in through a directed table and then random endpoints;
// every pixel item that comes out is checked in order against table pixels
// or a midpoint walk computed here, with random idling on both the command
// and pixel sides
module tb_top;

    localparam int NUM_ROWS     = 24;
    localparam int RANDOM_LINES = 126;
    localparam int DRAIN_CYCLES = 70;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_PIXELS   = 1 << mlr_pkg::COORD_BITS;

    typedef logic [mlr_pkg::COORD_BITS-1:0]      coord_t;
    typedef logic signed [mlr_pkg::DEC_BITS-1:0] decision_t;
    typedef logic signed [mlr_pkg::INC_BITS-1:0] increment_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } pixel_t;

    // typed_count 0: pixels come from the line walk below
    typedef struct packed {
        coord_t     sx;
        coord_t     sy;
        coord_t     ex;
        coord_t     ey;
        logic [1:0] typed_count;
        pixel_t     p0;
        pixel_t     p1;
    } line_row_t;

    logic   clk;
    logic   rst_n      = 1'b0;
    logic   cmd_valid  = 1'b0;
    logic   cmd_ready;
    coord_t start_x    = '0;
    coord_t start_y    = '0;
    coord_t end_x      = '0;
    coord_t end_y      = '0;
    logic   pix_valid;
    logic   pix_ready  = 1'b0;
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;

    pixel_t    expected_pixels [$];
    line_row_t line_table [NUM_ROWS];
    int        mismatches  = 0;
    int        cycle_count = 0;
    bit        no_idle     = 1'b0;

    midpoint_line_rasterizer dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // walk the midpoint line between two endpoints and queue each pixel
    function automatic void walk_line(input coord_t ax, input coord_t ay,
                                      input coord_t bx, input coord_t by);
        coord_t           x0;
        coord_t           y0;
        coord_t           x1;
        coord_t           y1;
        coord_t           wx;
        coord_t           wy;
        coord_t           stop;
        int               dx;
        int               dy;
        int               count;
        decision_t        dec;
        increment_t       inc_straight;
        increment_t       inc_diag;
        mlr_pkg::octant_t oct;
        logic             diag;
        x0 = ax;
        y0 = ay;
        x1 = bx;
        y1 = by;
        // x never decreases along the walk
        if (bx < ax)
        begin
            x0 = bx;
            y0 = by;
            x1 = ax;
            y1 = ay;
        end
        dx = int'(x1) - int'(x0);
        dy = int'(y1) - int'(y0);
        if (dy >= 0 && dy <= dx)
        begin
            oct          = mlr_pkg::OCT_SHALLOW_POS;
            dec          = decision_t'(2 * dy - dx);
            inc_straight = increment_t'(2 * dy);
            inc_diag     = increment_t'(2 * (dy - dx));
            stop         = x1;
        end
        else if (dy < 0 && -dy <= dx)
        begin
            oct          = mlr_pkg::OCT_SHALLOW_NEG;
            dec          = decision_t'(2 * dy + dx);
            inc_straight = increment_t'(2 * dy);
            inc_diag     = increment_t'(2 * (dy + dx));
            stop         = x1;
        end
        else if (dy > dx)
        begin
            oct          = mlr_pkg::OCT_STEEP_POS;
            dec          = decision_t'(2 * dx - dy);
            inc_straight = increment_t'(2 * dx);
            inc_diag     = increment_t'(2 * (dx - dy));
            stop         = y1;
        end
        else
        begin
            oct          = mlr_pkg::OCT_STEEP_NEG;
            dec          = decision_t'(dy + 2 * dx);
            inc_straight = increment_t'(2 * dx);
            inc_diag     = increment_t'(2 * (dy + dx));
            stop         = y1;
        end
        wx    = x0;
        wy    = y0;
        count = 0;
        while ((((oct == mlr_pkg::OCT_SHALLOW_POS) || (oct == mlr_pkg::OCT_SHALLOW_NEG))
                ? wx : wy) != stop
               && count < MAX_PIXELS - 1)
        begin
            expected_pixels.push_back({wx, wy, 1'b0});
            count++;
            // a tie goes diagonal only in the shallow negative case
            diag = (oct == mlr_pkg::OCT_SHALLOW_NEG) ? (dec <= 0) : (dec > 0);
            dec  = dec + (diag ? inc_diag : inc_straight);
            case (oct)
                mlr_pkg::OCT_SHALLOW_POS:
                begin
                    wx = wx + 1'b1;
                    if (diag) wy = wy + 1'b1;
                end
                mlr_pkg::OCT_SHALLOW_NEG:
                begin
                    wx = wx + 1'b1;
                    if (diag) wy = wy - 1'b1;
                end
                mlr_pkg::OCT_STEEP_POS:
                begin
                    wy = wy + 1'b1;
                    if (diag) wx = wx + 1'b1;
                end
                default:
                begin
                    wy = wy - 1'b1;
                    if (diag) wx = wx + 1'b1;
                end
            endcase
        end
        expected_pixels.push_back({wx, wy, 1'b1});
    endfunction

    task automatic send_line(input line_row_t row);
        while (!no_idle && $urandom_range(0, 99) < 32)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        start_x   <= row.sx;
        start_y   <= row.sy;
        end_x     <= row.ex;
        end_y     <= row.ey;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        if (row.typed_count == 2'd0)
        begin
            walk_line(row.sx, row.sy, row.ex, row.ey);
        end
        else
        begin
            expected_pixels.push_back(row.p0);
            if (row.typed_count == 2'd2) expected_pixels.push_back(row.p1);
        end
    endtask

    task automatic wait_all_pixels();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (expected_pixels.size() != 0);
    endtask

    initial
    begin
        line_row_t rnd;
        int        kind;
        int        len;
        line_table = '{
            // zero length, one pixel marked last
            {6'd0,  6'd0,  6'd0,  6'd0,  2'd1, {6'd0,  6'd0,  1'b1}, 13'd0},
            {6'd63, 6'd63, 6'd63, 6'd63, 2'd1, {6'd63, 6'd63, 1'b1}, 13'd0},
            // two-pixel lines, forward, swapped, up and down
            {6'd5,  6'd5,  6'd6,  6'd5,  2'd2, {6'd5,  6'd5,  1'b0}, {6'd6,  6'd5,  1'b1}},
            {6'd6,  6'd5,  6'd5,  6'd5,  2'd2, {6'd5,  6'd5,  1'b0}, {6'd6,  6'd5,  1'b1}},
            {6'd10, 6'd20, 6'd10, 6'd21, 2'd2, {6'd10, 6'd20, 1'b0}, {6'd10, 6'd21, 1'b1}},
            {6'd10, 6'd21, 6'd10, 6'd20, 2'd2, {6'd10, 6'd21, 1'b0}, {6'd10, 6'd20, 1'b1}},
            // full-tile horizontals, diagonals and verticals
            {6'd0,  6'd0,  6'd63, 6'd0,  2'd0, 13'd0, 13'd0},
            {6'd63, 6'd0,  6'd0,  6'd0,  2'd0, 13'd0, 13'd0},
            {6'd0,  6'd0,  6'd63, 6'd63, 2'd0, 13'd0, 13'd0},
            {6'd0,  6'd63, 6'd63, 6'd0,  2'd0, 13'd0, 13'd0},
            {6'd63, 6'd63, 6'd0,  6'd0,  2'd0, 13'd0, 13'd0},
            {6'd0,  6'd0,  6'd0,  6'd63, 2'd0, 13'd0, 13'd0},
            {6'd0,  6'd63, 6'd0,  6'd0,  2'd0, 13'd0, 13'd0},
            {6'd63, 6'd0,  6'd63, 6'd63, 2'd0, 13'd0, 13'd0},
            // slopes just off one, each octant
            {6'd0,  6'd0,  6'd63, 6'd62, 2'd0, 13'd0, 13'd0},
            {6'd0,  6'd0,  6'd62, 6'd63, 2'd0, 13'd0, 13'd0},
            {6'd0,  6'd63, 6'd62, 6'd0,  2'd0, 13'd0, 13'd0},
            {6'd0,  6'd63, 6'd63, 6'd1,  2'd0, 13'd0, 13'd0},
            // initial decision of zero in each octant, then a steep falling line and a swapped anti-diagonal
            {6'd3,  6'd7,  6'd9,  6'd10, 2'd0, 13'd0, 13'd0},
            {6'd3,  6'd10, 6'd9,  6'd7,  2'd0, 13'd0, 13'd0},
            {6'd7,  6'd3,  6'd10, 6'd9,  2'd0, 13'd0, 13'd0},
            {6'd7,  6'd9,  6'd10, 6'd3,  2'd0, 13'd0, 13'd0},
            {6'd20, 6'd40, 6'd45, 6'd12, 2'd0, 13'd0, 13'd0},
            {6'd63, 6'd0,  6'd0,  6'd63, 2'd0, 13'd0, 13'd0}
        };
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < NUM_ROWS; i++) send_line(line_table[i]);
        wait_all_pixels();
        for (int i = 0; i < RANDOM_LINES; i++)
        begin
            no_idle = (i >= 40 && i < 80);
            if (i == 100) wait_all_pixels();
            rnd             = '0;
            rnd.sx          = coord_t'($urandom_range(0, 63));
            rnd.sy          = coord_t'($urandom_range(0, 63));
            rnd.ex          = coord_t'($urandom_range(0, 63));
            rnd.ey          = coord_t'($urandom_range(0, 63));
            kind            = int'($urandom_range(0, 9));
            case (kind)
                0: begin rnd.ex = rnd.sx; rnd.ey = rnd.sy; end
                1: rnd.ey = rnd.sy;
                2: rnd.ex = rnd.sx;
                3:
                begin
                    // exact diagonal, rising or falling
                    len    = int'($urandom_range(0, 31));
                    rnd.sx = coord_t'($urandom_range(0, 31));
                    rnd.sy = coord_t'($urandom_range(0, 31));
                    rnd.ex = rnd.sx + coord_t'(len);
                    if ($urandom_range(0, 1) == 0)
                    begin
                        rnd.ey = rnd.sy + coord_t'(len);
                    end
                    else
                    begin
                        rnd.sy = 6'd63 - rnd.sy;
                        rnd.ey = rnd.sy - coord_t'(len);
                    end
                end
                default: ;
            endcase
            send_line(rnd);
        end
        no_idle = 1'b0;
        wait_all_pixels();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    always @(posedge clk)
    begin
        pix_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 32);
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && pix_valid && pix_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("pixel item with none expected: x %0d y %0d last %0d",
                       pixel_x, pixel_y, last_pixel);
                mismatches++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (pixel_x !== want.x)
                begin
                    $error("pixel_x: expected %0d, actual %0d", want.x, pixel_x);
                    mismatches++;
                end
                if (pixel_y !== want.y)
                begin
                    $error("pixel_y: expected %0d, actual %0d", want.y, pixel_y);
                    mismatches++;
                end
                if (last_pixel !== want.last)
                begin
                    $error("last_pixel: expected %0d, actual %0d", want.last, last_pixel);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

FILE: midpoint_line_rasterizer.f
src/mlr_pkg.sv
src/mlr_datapath.sv
src/mlr_controller.sv
src/midpoint_line_rasterizer.sv
test/tb_top.sv
